// ===== rtl/ec_pkg.sv =====
// shared types, constants and arithmetic helpers for the 3x3 rgb emboss filter
// no dependencies
package ec_pkg;

    // window geometry defaults
    localparam int WinColsDef = 3;
    localparam int WinRowsDef = 3;

    // fixed field widths
    localparam int PixW   = 8;
    localparam int SumW   = 16;
    localparam int CoefW  = 36;
    localparam int BiasW  = 10;
    localparam int WtW    = 4;
    localparam int TapIdxW = 4;
    localparam int CoefTaps = 9;
    localparam int NumChan  = 3;
    localparam int ProdW  = PixW + WtW + 1;

    // configuration register map
    localparam int AddrW = 4;
    localparam int DataW = 64;
    localparam logic [AddrW-1:0] AddrCoef = 4'h0;
    localparam logic [AddrW-1:0] AddrBias = 4'h8;

    // reset values of the registers
    localparam logic [CoefW-1:0] CoefReset = 36'h11010F0FF;
    localparam logic signed [BiasW-1:0] BiasReset = 10'sd128;

    localparam int PixMax = 255;

    typedef logic signed [SumW-1:0] t_sum;
    typedef logic [PixW-1:0] t_pix;

    // per-item control handed to every lane
    typedef struct packed {
        logic acc_en;
        logic last;
    } t_lane_ctl;

    // weight of one tap, zero for taps beyond the coefficient register
    function automatic logic signed [WtW-1:0] tap_weight(
        input logic [CoefW-1:0]   coef,
        input logic [TapIdxW-1:0] idx
    );
        logic signed [WtW-1:0] w;
        w = '0;
        if (idx < TapIdxW'(CoefTaps)) begin
            w = coef[WtW*idx +: WtW];
        end
        return w;
    endfunction

    // biased sum clamped to 0..255
    function automatic t_pix clamp_chan(
        input t_sum                   s,
        input logic signed [BiasW-1:0] b
    );
        logic signed [SumW:0] v;
        t_pix r;
        v = (SumW+1)'(s) + (SumW+1)'(b);
        if (v < 0) begin
            r = '0;
        end else if (v > (SumW+1)'(PixMax)) begin
            r = PixW'(PixMax);
        end else begin
            r = v[PixW-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/ec_lane.sv =====
// one channel lane: multiply-accumulate of a pixel by its tap weight
// depends on ec_pkg
module ec_lane (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ec_pkg::t_lane_ctl                i_ctl,
    input  ec_pkg::t_pix                     i_pix,
    input  logic signed [ec_pkg::WtW-1:0]    i_weight,
    output ec_pkg::t_sum                     o_sum
);
    import ec_pkg::*;

    t_sum r_acc, n_acc;
    t_sum r_done, n_done;
    logic signed [ProdW-1:0] w_prod;
    t_sum w_total;

    // product of unsigned pixel and signed weight, then running sum
    assign w_prod  = $signed({1'b0, i_pix}) * ProdW'(i_weight);
    assign w_total = r_acc + SumW'(w_prod);

    always_comb begin
        n_acc  = r_acc;
        n_done = r_done;
        if (i_ctl.acc_en) begin
            if (i_ctl.last) begin
                n_acc  = '0;
                n_done = w_total;
            end else begin
                n_acc = w_total;
            end
        end
    end

    // accumulator is state, finished sum is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
        r_done <= n_done;
    end

    assign o_sum = r_done;

endmodule

// ===== rtl/ec_merge.sv =====
// merging stage: adds bias, clamps each lane and holds the result item
// depends on ec_pkg
module ec_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ec_pkg::t_sum                      i_sum [ec_pkg::NumChan],
    input  logic                              i_done_vld,
    input  logic signed [ec_pkg::BiasW-1:0]   i_bias,
    input  logic                              i_out_rdy,
    output logic                              o_take,
    output logic                              o_out_vld,
    output ec_pkg::t_pix                      o_out [ec_pkg::NumChan]
);
    import ec_pkg::*;

    logic r_vld, n_vld;
    t_pix r_out [NumChan];
    t_pix n_out [NumChan];

    // a finished window moves in when the output register is free or drains
    assign o_take = i_done_vld && (!r_vld || i_out_rdy);

    always_comb begin
        n_vld = r_vld;
        if (o_take) begin
            n_vld = 1'b1;
        end else if (i_out_rdy) begin
            n_vld = 1'b0;
        end
        for (int c = 0; c < NumChan; c++) begin
            n_out[c] = o_take ? clamp_chan(i_sum[c], i_bias) : r_out[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_out <= n_out;
    end

    assign o_out_vld = r_vld;
    assign o_out     = r_out;

endmodule

// ===== rtl/emboss_convolution_3x3_rgb.sv =====
// top level of the 3x3 rgb emboss filter: config registers, tap counter,
// three channel lanes and the merging stage; depends on ec_pkg, ec_lane, ec_merge
//
// The block takes the WIN_COLS*WIN_ROWS pixels of one window, one pixel per
// item in row-major order, and returns one item with the three clamped channel
// values after the last pixel of the window. Each channel has its own
// multiply-accumulate lane, so a pixel can be taken every clock cycle unless input
// is stalled; the result goes through a finished-sum register and a clamp/output
// register before it is valid on the output.
// Input is stalled only while both result registers are full and the output
// side is not taking.
// Coefficients (36 bits, nine 4-bit signed weights, tap k at bits 4k+3..4k)
// sit at byte address 0x0 and the signed 10-bit bias at 0x8; write them only
// between windows.
module emboss_convolution_3x3_rgb #(
    parameter int WIN_COLS = ec_pkg::WinColsDef,
    parameter int WIN_ROWS = ec_pkg::WinRowsDef
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ec_pkg::AddrW-1:0]   paddr,
    input  logic [ec_pkg::DataW-1:0]   pwdata,
    output logic [ec_pkg::DataW-1:0]   prdata,
    output logic                       pready,
    // pixel input
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [23:0]                s_axis_tdata,  // chan_low, chan_mid, chan_high
    // result output
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    output logic [23:0]                m_axis_tdata   // out_low, out_mid, out_high
);
    import ec_pkg::*;

    localparam int NumTaps = WIN_COLS * WIN_ROWS;
    localparam int TapW    = (NumTaps > 1) ? $clog2(NumTaps) : 1;

    logic [CoefW-1:0]        r_coef, n_coef;
    logic signed [BiasW-1:0] r_bias, n_bias;
    logic [TapW-1:0]         r_tap, n_tap;
    logic                    r_done_vld, n_done_vld;

    logic                    w_wr;
    logic                    w_accept;
    logic                    w_last;
    logic                    w_take;
    logic signed [WtW-1:0]   w_weight;
    t_lane_ctl               w_ctl;
    t_sum                    w_sum [NumChan];
    t_pix                    w_pix [NumChan];
    t_pix                    w_out [NumChan];

    // configuration writes and reads
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    always_comb begin
        n_coef = r_coef;
        n_bias = r_bias;
        if (w_wr) begin
            case (paddr)
                AddrCoef: n_coef = pwdata[CoefW-1:0];
                AddrBias: n_bias = pwdata[BiasW-1:0];
                default:  ;
            endcase
        end
    end

    always_comb begin
        case (paddr)
            AddrCoef: prdata = DataW'(r_coef);
            AddrBias: prdata = DataW'(unsigned'(r_bias));
            default:  prdata = '0;
        endcase
    end

    // input handshake and tap position
    assign s_axis_tready = !r_done_vld || w_take;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last        = (r_tap == TapW'(NumTaps - 1));
    assign w_weight      = tap_weight(r_coef, TapIdxW'(r_tap));
    assign w_ctl         = '{acc_en: w_accept, last: w_last};

    always_comb begin
        n_tap      = r_tap;
        n_done_vld = r_done_vld;
        if (w_accept) begin
            n_tap = w_last ? '0 : r_tap + 1'b1;
        end
        if (w_accept && w_last) begin
            n_done_vld = 1'b1;
        end else if (w_take) begin
            n_done_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef     <= CoefReset;
            r_bias     <= BiasReset;
            r_tap      <= '0;
            r_done_vld <= 1'b0;
        end else begin
            r_coef     <= n_coef;
            r_bias     <= n_bias;
            r_tap      <= n_tap;
            r_done_vld <= n_done_vld;
        end
    end

    // one lane per color channel
    assign w_pix[0] = s_axis_tdata[7:0];
    assign w_pix[1] = s_axis_tdata[15:8];
    assign w_pix[2] = s_axis_tdata[23:16];

    for (genvar c = 0; c < NumChan; c++) begin : g_lane
        ec_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_pix    (w_pix[c]),
            .i_weight (w_weight),
            .o_sum    (w_sum[c])
        );
    end

    // bias, clamp and output register
    ec_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_sum      (w_sum),
        .i_done_vld (r_done_vld),
        .i_bias     (r_bias),
        .i_out_rdy  (m_axis_tready),
        .o_take     (w_take),
        .o_out_vld  (m_axis_tvalid),
        .o_out      (w_out)
    );

    assign m_axis_tdata = {w_out[2], w_out[1], w_out[0]};

endmodule
